FILE: design/tcw_pkg.sv
`timescale 1ns / 1ps
// constants shared by the text console writer and its port checker
// no dependencies

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int OFF_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int REP_W   = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;
  localparam logic [REP_W-1:0]  TAB_EXTRA    = 3'd6;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

endpackage

FILE: design/text_console_writer_top.sv
`timescale 1ns / 1ps
// text console writer: 80x25 character store with cursor, put and read beats
// depends on tcw_pkg

// After reset the block runs a clearing pass over the 2000-cell store, one
// cell a cycle, and holds in_tready low until the pass ends. A read beat
// goes from idle through S_RD to S_RESP, a plain put or a newline through
// S_PUT to S_RESP, and a tab (seven spaces) stays in S_PUT for each space;
// a put that scrolls passes S_MOVE and S_FILL on the way. S_RESP loads the
// result register once it is free, and in_tready comes back as it loads.
// The store has one write and one registered read port, so a scroll walks
// it one cell a cycle: 1920 row moves, a drain of the last moved cell and
// 80 space fills. The block takes one item at a time; in_tready is high only
// while it is idle, and a finished result waits in the output register.
module text_console_writer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]   in_tdata,   // char_code[7:0], cell_index[18:8]
  input  logic                             in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata   // read_char[7:0], out_row[12:8],
                                                       // out_col[19:13], out_offset[30:20]
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PUT, S_RD, S_MOVE, S_FILL, S_RESP
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'(CELLS - COLUMNS);

  state_t               state_r;
  logic [ADDR_W-1:0]    cnt_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_W-1:0]     col_r;
  logic [ADDR_W-1:0]    pos_r;
  logic [CHAR_W-1:0]    ch_r;
  logic [REP_W-1:0]     rep_r;
  logic                 rd_ok_r;
  logic [CHAR_W-1:0]    rchar_r;
  logic                 wr_pend_r;
  logic [ADDR_W-1:0]    wr_addr_r;
  logic                 out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [CHAR_W-1:0]    mem [CELLS];
  logic [CHAR_W-1:0]    rdata_r;

  logic                 we;
  logic [ADDR_W-1:0]    wa;
  logic [CHAR_W-1:0]    wd;
  logic [ADDR_W-1:0]    ra;

  logic [CHAR_W-1:0]    in_char;
  logic [OFF_W-1:0]     in_idx;
  logic [ADDR_W:0]      pos_inc;
  logic [ADDR_W:0]      move_src;
  logic                 accept;
  logic                 out_free;

  assign in_char  = in_tdata[CHAR_W-1:0];
  assign in_idx   = in_tdata[CHAR_W+OFF_W-1:CHAR_W];
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign move_src = {1'b0, cnt_r} + (ADDR_W+1)'(COLUMNS);
  assign in_tready = (state_r == S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // store port selection
  always_comb begin
    we = 1'b0;
    wa = cnt_r;
    wd = '0;
    ra = move_src[ADDR_W-1:0];
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        ra = in_idx[ADDR_W-1:0];
      end
      S_PUT: begin
        if (ch_r != CODE_NEWLINE) begin
          we = 1'b1;
          wa = pos_r;
          wd = ch_r;
        end
      end
      S_FILL: begin
        we = 1'b1;
        wd = CODE_SPACE;
      end
      default: ;
    endcase
    // a moved cell lands in the cycle after its read
    if (wr_pend_r) begin
      we = 1'b1;
      wa = wr_addr_r;
      wd = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      rep_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pend_r <= (state_r == S_MOVE);
      wr_addr_r <= cnt_r;
      // a new result loads once the register is free, else a taken beat clears it
      out_valid_r <= ((state_r == S_RESP) && out_free) || (out_valid_r && !out_tready);
      case (state_r)
        S_CLEAR: begin
          if (cnt_r == LAST_CELL) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rchar_r <= '0;
            rd_ok_r <= (in_idx < OFF_W'(CELLS));
            if (in_tuser == FUNC_READ) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_PUT;
              if (in_char == CODE_TAB) begin
                ch_r  <= CODE_SPACE;
                rep_r <= TAB_EXTRA;
              end else begin
                ch_r  <= in_char;
                rep_r <= '0;
              end
            end
          end
        end
        S_RD: begin
          rchar_r <= rd_ok_r ? rdata_r : '0;
          state_r <= S_RESP;
        end
        S_PUT: begin
          if (ch_r == CODE_NEWLINE) begin
            col_r <= '0;
            if (row_r < ROW_W'(ROWS - 1)) begin
              row_r   <= row_r + 1'b1;
              pos_r   <= pos_r - ADDR_W'(col_r) + ADDR_W'(COLUMNS);
              state_r <= S_RESP;
            end else begin
              pos_r   <= LAST_ROW0;
              cnt_r   <= '0;
              state_r <= S_MOVE;
            end
          end else if (pos_inc == (ADDR_W+1)'(CELLS)) begin
            row_r   <= ROW_W'(ROWS - 1);
            col_r   <= '0;
            pos_r   <= LAST_ROW0;
            cnt_r   <= '0;
            state_r <= S_MOVE;
          end else begin
            pos_r <= pos_inc[ADDR_W-1:0];
            if (col_r == COL_W'(COLUMNS - 1)) begin
              col_r <= '0;
              row_r <= row_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
            end
            if (rep_r != '0) begin
              rep_r <= rep_r - 1'b1;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_MOVE: begin
          if (cnt_r == LAST_MOVE) begin
            cnt_r   <= LAST_ROW0;
            state_r <= S_FILL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FILL: begin
          if (!wr_pend_r) begin
            if (cnt_r == LAST_CELL) begin
              if (rep_r != '0) begin
                rep_r   <= rep_r - 1'b1;
                state_r <= S_PUT;
              end else begin
                state_r <= S_RESP;
              end
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r  <= {1'b0, OFF_W'(pos_r), col_r, row_r, rchar_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/tcw_port_checker.sv
`timescale 1ns / 1ps
// port-level checker for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_top

module tcw_port_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tcw_pkg::*;

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [OFF_W-1:0] off;

  assign row = out_tdata[12:8];
  assign col = out_tdata[19:13];
  assign off = out_tdata[30:20];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(off) == 32'(row) * COLUMNS + 32'(col)))
    else $error("cursor offset disagrees with row and column");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(row) < ROWS) && (32'(col) < COLUMNS))
    else $error("cursor outside the screen");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while an item is in work");

endmodule

bind text_console_writer_top tcw_port_checker u_tcw_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
